[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Request kinds, result status codes and the per-cycle cell control group.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned KindBits   = 3;
  localparam int unsigned StatusBits = 2;

  // Request kinds carried in the low bits of the input tdata
  typedef enum logic [KindBits-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [StatusBits-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic shift_in_front;   // all words move one cell back, new word enters cell 0
    logic shift_out_front;  // all words move one cell forward, cell 0 leaves
    logic append_back;      // first empty cell takes the new word
    logic drop_back;        // last occupied cell empties
  } dq_ctrl_t;

endpackage

[rtl/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue chain
// Holds one word and an occupied flag, and trades its word with its
// neighbors when the queue shifts at the front.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dq_ctrl_t             ctrl_i,
  input  logic [WORD_BITS-1:0] push_word_i,
  input  logic [WORD_BITS-1:0] prev_word_i,   // neighbor toward the front
  input  logic                 prev_valid_i,
  input  logic [WORD_BITS-1:0] next_word_i,   // neighbor toward the back
  input  logic                 next_valid_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] tail_word_o    // own word if this cell is the back
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 valid_q, valid_d;
  logic                 is_tail;

  assign is_tail = valid_q & ~next_valid_i;

  // Select the next contents from the broadcast operation
  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    if (ctrl_i.shift_in_front) begin
      word_d  = prev_word_i;
      valid_d = prev_valid_i;
    end else if (ctrl_i.shift_out_front) begin
      word_d  = next_word_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.append_back) begin
      if (!valid_q && prev_valid_i) begin
        word_d  = push_word_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.drop_back) begin
      if (is_tail) begin
        valid_d = 1'b0;
      end
    end
  end

  // Hold the occupied flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the word
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o      = word_q;
  assign valid_o     = valid_q;
  assign tail_word_o = is_tail ? word_q : '0;

endmodule

[rtl/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of signed words
// A chain of cells with the front word always in cell 0. Pushes and pops
// at the front shift the whole chain; the back end is found by each cell
// from its own and its neighbor's occupied flag.
//
//   channel   direction  tdata (low bit up)                 tuser  tlast
//   s_axis    in         kind, value                        -      -
//   m_axis    out        word, status, occupancy            -      -
//
// One request is taken per cycle while the output is not stalled; each gives
// one result in the next cycle. The chain updates as a request is taken, so
// the next request sees the new state at once. The result register frees
// when m_axis_tready is high, so a stalled output holds back s_axis_tready.
// Reset empties the queue immediately; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned CountBits = $clog2(DEPTH + 1),
  localparam int unsigned InBits    = KindBits + WORD_BITS,
  localparam int unsigned InBytes   = (InBits + 7) / 8,
  localparam int unsigned OutBits   = WORD_BITS + StatusBits + CountBits,
  localparam int unsigned OutBytes  = (OutBits + 7) / 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [InBytes*8-1:0]  s_axis_tdata,   // kind, value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OutBytes*8-1:0] m_axis_tdata    // word, status, occupancy
);

  // Decode the incoming transaction
  logic                 in_accept;
  kind_e                kind;
  logic [WORD_BITS-1:0] value;

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign kind      = kind_e'(s_axis_tdata[KindBits-1:0]);
  assign value     = s_axis_tdata[KindBits +: WORD_BITS];

  // Cell chain
  dq_ctrl_t             ctrl;
  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic [WORD_BITS-1:0] cell_tail [DEPTH];
  logic [DEPTH-1:0]     cell_valid;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_word, next_word;
    logic                 prev_valid, next_valid;

    if (i == 0) begin : g_head
      assign prev_word  = value;
      assign prev_valid = 1'b1;
    end else begin : g_mid_prev
      assign prev_word  = cell_word[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_word  = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid_next
      assign next_word  = cell_word[i+1];
      assign next_valid = cell_valid[i+1];
    end

    dq_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .push_word_i (value),
      .prev_word_i (prev_word),
      .prev_valid_i(prev_valid),
      .next_word_i (next_word),
      .next_valid_i(next_valid),
      .word_o      (cell_word[i]),
      .valid_o     (cell_valid[i]),
      .tail_word_o (cell_tail[i])
    );
  end

  // Gather the back word: at most one cell drives a nonzero tail word
  logic [WORD_BITS-1:0] back_word;
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  // Occupancy and request handling
  logic [CountBits-1:0] count_q, count_d;
  logic                 is_full, is_empty;
  logic [WORD_BITS-1:0] res_word;
  status_e              res_status;

  assign is_full  = (count_q == CountBits'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    ctrl       = '0;
    count_d    = count_q;
    res_word   = '0;
    res_status = STATUS_DONE;
    unique case (kind)
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          res_status = STATUS_FULL;
        end else begin
          ctrl.shift_in_front = in_accept;
          count_d             = count_q + CountBits'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (is_full) begin
          res_status = STATUS_FULL;
        end else begin
          ctrl.append_back = in_accept;
          count_d          = count_q + CountBits'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_word             = cell_word[0];
          ctrl.shift_out_front = in_accept;
          count_d              = count_q - CountBits'(1);
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_word       = back_word;
          ctrl.drop_back = in_accept;
          count_d        = count_q - CountBits'(1);
        end
      end
      KIND_PEEK_FRONT: begin
        if (is_empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_word = cell_word[0];
        end
      end
      default: begin
        // unknown kinds leave the queue as it is
      end
    endcase
  end

  // Advance the occupancy count on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_accept) begin
      count_q <= count_d;
    end
  end

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic [OutBytes*8-1:0] out_data_q, out_data_d;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    out_data_d = '0;
    out_data_d[WORD_BITS-1:0]                      = res_word;
    out_data_d[WORD_BITS +: StatusBits]             = res_status;
    out_data_d[WORD_BITS + StatusBits +: CountBits] = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // Count matches the number of occupied cells
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("occupancy count disagrees with occupied cells");

  // Occupied cells form an unbroken run from the front
  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("gap in occupied cells");

  // A push into a full queue leaves the count unchanged
  a_full_push_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_full &&
     (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK)) |=> $stable(count_q))
    else $error("push into full queue changed the count");

  // Count never exceeds the depth
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(DEPTH))
    else $error("occupancy beyond depth");
`endif

endmodule
